>>> rtl/core/icfm_pkg.sv
// Shared types and constants of the input capture frequency meter.
// Holds the channel payload structs, the request and register codes and
// the command/status structs between controller and datapath.
package icfm_pkg;

    localparam int REQ_W     = 2;
    localparam int CAP_W     = 16;
    localparam int FREQ_W    = 27;
    localparam int TARGET_W  = 10;
    localparam int MS_W      = 16;
    localparam int SUM_W     = 37;
    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 2;
    localparam int ROLL_W    = 2;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_CAPTURE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ROLLOVER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_START    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Register reset values
    localparam logic [FREQ_W-1:0]   RST_TIMER_HZ = 27'd64000000;
    localparam logic [TARGET_W-1:0] RST_TARGET   = 10'd100;
    localparam logic [MS_W-1:0]     RST_TIMEOUT  = 16'd50;

    localparam logic [ROLL_W-1:0] ROLL_MAX = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [CAP_W-1:0] capture_value;
    } t_in;

    typedef struct packed {
        logic [FREQ_W-1:0] measured_freq;
        logic [FREQ_W-1:0] average_freq;
        logic              average_done;
        logic              timed_out;
    } t_out;

    typedef struct packed {
        logic latch;          // capture the accepted input item
        logic start_freq;     // start timer_clock / period division
        logic apply_capture;  // commit capture results
        logic start_avg;      // start sum / target division
        logic finish_avg;     // commit the mean into the result
        logic apply_event;    // commit rollover, tick or start
        logic load_out;       // move result into the output register
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             avg_hit;
        logic             div_done;
    } t_sts;

endpackage

>>> rtl/core/input_capture_frequency_meter.sv
// Top level of the input capture frequency meter.
// Instantiates icfm_ctrl and icfm_datapath; uses icfm_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) carries one timer
//   event per transfer: capture edge with counter value, counter rollover,
//   millisecond tick or start-averaging request.
//   Output channel (o_out_valid / i_out_ready, payload o_out) returns exactly
//   one result per event: current frequency, mean, done and timeout flags.
//   Configuration: write i_cfg_data to register i_cfg_index while
//   i_cfg_wr_en is high (0 timer clock, 1 sample target, 2 timeout in ms);
//   unused indexes are dropped. Write only while no event is in flight.
// Sequencing:
//   One event is worked on at a time. Rollover, tick and start are decoded
//   and committed directly. A capture runs the 37-step serial divider
//   forming timer_clock / period; a capture that completes an averaging
//   run reuses the divider for sum / target.
// Reset: synchronous, active low; clears all measurement state and loads
//   the register defaults. No clearing pass is needed.
// Stall: the result sits in an output register, so the next event is taken
//   while it waits; a further result holds until the output is drained.
module input_capture_frequency_meter #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [icfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [icfm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  icfm_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output icfm_pkg::t_out                  o_out
);
    import icfm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence each event: decode, divide, commit, then push the result
    icfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Hold configuration, period/frequency state, accumulator and divider
    icfm_datapath #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule

>>> rtl/core/icfm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Stand-alone; used by icfm_datapath for both frequency and mean.
module icfm_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] shifted;
    logic           fits;

    assign shifted = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

>>> rtl/core/icfm_datapath.sv
// Datapath of the frequency meter: configuration, measurement state,
// period formation, shared divider, result and output registers. Uses icfm_pkg, icfm_div.
module icfm_datapath #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [icfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [icfm_pkg::CFG_W-1:0]      i_cfg_data,
    input  icfm_pkg::t_in                   i_in,
    input  icfm_pkg::t_cmd                  i_cmd,
    output icfm_pkg::t_sts                  o_sts,
    output icfm_pkg::t_out                  o_out
);
    import icfm_pkg::*;

    localparam int PER_W  = COUNTER_WIDTH + 1;
    localparam int DEN_W  = (PER_W > TARGET_W) ? PER_W : TARGET_W;
    localparam int CAP_XW = (COUNTER_WIDTH > CAP_W) ? COUNTER_WIDTH : CAP_W;

    // Configuration
    logic [FREQ_W-1:0]   r_timer_hz;
    logic [TARGET_W-1:0] r_target;
    logic [MS_W-1:0]     r_timeout;

    // Measurement state
    logic [COUNTER_WIDTH-1:0] r_last;
    logic [FREQ_W-1:0]        r_freq;
    logic [ROLL_W-1:0]        r_roll;
    logic [TARGET_W-1:0]      r_count;
    logic [SUM_W-1:0]         r_sum;
    logic [MS_W-1:0]          r_elapsed;
    logic                     r_active;

    // Payload
    t_in  r_req;
    t_out r_res;
    t_out r_out;

    logic [CAP_XW-1:0]        cap_x;
    logic [COUNTER_WIDTH-1:0] cur;
    logic [PER_W-1:0]         period;
    logic [SUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic [SUM_W-1:0]         div_quo;
    logic                     div_done;
    logic [FREQ_W-1:0]        freq_q;
    logic [TARGET_W-1:0]      n_count;
    logic [SUM_W-1:0]         n_sum;
    logic                     avg_hit;
    logic [ROLL_W-1:0]        n_roll;
    logic [MS_W-1:0]          n_elapsed;
    t_out                     ev_res;

    // Period: plain difference, or one full counter wrap added when the
    // new value does not exceed the last one.
    assign cap_x  = CAP_XW'(r_req.capture_value);
    assign cur    = cap_x[COUNTER_WIDTH-1:0];
    assign period = {(cur <= r_last), cur} - {1'b0, r_last};

    assign freq_q  = div_quo[FREQ_W-1:0];
    assign n_count = r_count + TARGET_W'(1);
    assign n_sum   = r_sum + SUM_W'(freq_q);
    assign avg_hit = r_active && (n_count == r_target);

    assign n_roll    = (r_roll == ROLL_MAX) ? r_roll : r_roll + ROLL_W'(1);
    assign n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + MS_W'(1);

    assign div_num = i_cmd.start_avg ? n_sum : SUM_W'(r_timer_hz);
    assign div_den = i_cmd.start_avg ? DEN_W'(r_target) : DEN_W'(period);

    icfm_div #(
        .NUM_W(SUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_freq | i_cmd.start_avg),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // Result of a rollover, tick or start
    always_comb begin
        ev_res = '0;
        ev_res.measured_freq = r_freq;
        case (r_req.req_type)
            REQ_ROLLOVER: begin
                if (n_roll > ROLL_W'(1)) begin
                    ev_res.measured_freq = '0;
                end
            end
            REQ_TICK: begin
                ev_res.timed_out = r_active && (n_elapsed >= r_timeout);
            end
            REQ_START: begin
                ev_res.average_done = (r_target == '0);
                ev_res.timed_out    = (r_target != '0) && (r_timeout == '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_hz <= RST_TIMER_HZ;
            r_target   <= RST_TARGET;
            r_timeout  <= RST_TIMEOUT;
            r_last     <= '0;
            r_freq     <= '0;
            r_roll     <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_elapsed  <= '0;
            r_active   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TIMER_HZ: r_timer_hz <= i_cfg_data[FREQ_W-1:0];
                    CFG_TARGET:   r_target   <= i_cfg_data[TARGET_W-1:0];
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.apply_event) begin
                case (r_req.req_type)
                    REQ_ROLLOVER: begin
                        r_roll <= n_roll;
                        if (n_roll > ROLL_W'(1)) begin
                            r_freq <= '0;
                        end
                    end
                    REQ_TICK: begin
                        if (r_active) begin
                            r_elapsed <= n_elapsed;
                            if (n_elapsed >= r_timeout) begin
                                r_active <= 1'b0;
                            end
                        end
                    end
                    REQ_START: begin
                        r_count   <= '0;
                        r_sum     <= '0;
                        r_elapsed <= '0;
                        r_active  <= (r_target != '0) && (r_timeout != '0);
                    end
                    default: ;
                endcase
            end
            if (i_cmd.apply_capture) begin
                r_freq <= freq_q;
                r_last <= cur;
                r_roll <= '0;
                if (r_active) begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    if (avg_hit) begin
                        r_active <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_in;
        end
        if (i_cmd.apply_event) begin
            r_res <= ev_res;
        end else if (i_cmd.apply_capture) begin
            r_res <= '{measured_freq: freq_q, average_freq: '0,
                       average_done: 1'b0, timed_out: 1'b0};
        end else if (i_cmd.finish_avg) begin
            r_res.average_freq <= freq_q;
            r_res.average_done <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_sts = '{req_type: r_req.req_type, avg_hit: avg_hit, div_done: div_done};
    assign o_out = r_out;

endmodule

>>> rtl/core/icfm_ctrl.sv
// Controller of the frequency meter: input/output handshakes and the
// sequence of datapath commands for one event. Uses icfm_pkg.
module icfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  icfm_pkg::t_sts i_sts,
    output icfm_pkg::t_cmd o_cmd
);
    import icfm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DIV_FREQ = 3'd2;
    localparam logic [2:0] S_DIV_AVG  = 3'd3;
    localparam logic [2:0] S_PUSH     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.req_type == REQ_CAPTURE) begin
                    cmd.start_freq = 1'b1;
                    n_state        = S_DIV_FREQ;
                end else begin
                    cmd.apply_event = 1'b1;
                    n_state         = S_PUSH;
                end
            end
            S_DIV_FREQ: begin
                if (i_sts.div_done) begin
                    cmd.apply_capture = 1'b1;
                    if (i_sts.avg_hit) begin
                        cmd.start_avg = 1'b1;
                        n_state       = S_DIV_AVG;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_DIV_AVG: begin
                if (i_sts.div_done) begin
                    cmd.finish_avg = 1'b1;
                    n_state        = S_PUSH;
                end
            end
            S_PUSH: begin
                // Hold until the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = cmd.load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule
